/* rtl/frl_pkg.sv */
`timescale 1ns / 1ps

package frl_pkg;

    // table geometry
    localparam int BUCKETS    = 1024;
    localparam int BKT_BITS   = $clog2(BUCKETS);
    localparam int SLOTS      = 2 * BUCKETS;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int KEY_BITS   = 64;
    localparam int HOME_SHIFT = KEY_BITS - 16;

    // slot status codes
    localparam logic [1:0] ST_EMPTY  = 2'd0;
    localparam logic [1:0] ST_ACTIVE = 2'd1;
    localparam logic [1:0] ST_TOMB   = 2'd2;

    // verdict codes
    localparam logic [1:0] VERDICT_OK     = 2'd0;
    localparam logic [1:0] VERDICT_NOSRC  = 2'd1;
    localparam logic [1:0] VERDICT_LOCKED = 2'd2;
    localparam logic [1:0] VERDICT_FULL   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_MAX_FAILURES = 3'd0;
    localparam logic [2:0] CFG_WINDOW       = 3'd1;
    localparam logic [2:0] CFG_LOCKOUT      = 3'd2;
    localparam logic [2:0] CFG_IDLE_EXPIRY  = 3'd3;
    localparam logic [2:0] CFG_COMPACT_THR  = 3'd4;

    // configuration reset values
    localparam logic [7:0]  RST_MAX_FAILURES = 8'd5;
    localparam logic [15:0] RST_WINDOW       = 16'd30;
    localparam logic [15:0] RST_LOCKOUT      = 16'd300;
    localparam logic [15:0] RST_IDLE_EXPIRY  = 16'd3600;
    localparam logic [10:0] RST_COMPACT_THR  = 11'd768;

    typedef struct packed {
        logic [KEY_BITS-1:0] key_digest;
        logic                source_known;
        logic                fail_mark;
        logic [30:0]         now_seconds;
    } req_t;

    typedef struct packed {
        logic        allowed;
        logic [1:0]  verdict_code;
        logic        lock_started;
        logic [31:0] full_rejections;
    } rsp_t;

    // one table slot as stored in memory
    typedef struct packed {
        logic [1:0]          status;
        logic [KEY_BITS-1:0] key;
        logic [7:0]          failures;
        logic [31:0]         first_time;
        logic [31:0]         lock_end;
        logic [31:0]         touch_time;
    } slot_t;

    // shared time unit operands and results
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [15:0] lim;
    } tu_req_t;

    typedef struct packed {
        logic        a_gt_b;
        logic        elapsed_gt;
        logic [31:0] sum;
    } tu_rsp_t;

    // home bucket: top 16 bits of the key, modulo the bucket count
    function automatic logic [BKT_BITS-1:0] home_of(input logic [KEY_BITS-1:0] key);
        logic [15:0] top;
        top = key[HOME_SHIFT +: 16];
        return top[BKT_BITS-1:0];
    endfunction

endpackage

/* rtl/frl_ram.sv */
`timescale 1ns / 1ps

module frl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/frl_time_unit.sv */
`timescale 1ns / 1ps

module frl_time_unit (
    input  frl_pkg::tu_req_t req,
    output frl_pkg::tu_rsp_t rsp
);

    logic [31:0] diff;

    // elapsed time compare and deadline add
    always_comb begin
        diff           = req.a - req.b;
        rsp.a_gt_b     = req.a > req.b;
        rsp.elapsed_gt = rsp.a_gt_b && (diff > {16'd0, req.lim});
        rsp.sum        = req.a + {16'd0, req.lim};
    end

endmodule

/* rtl/failure_rate_limit_hash_table_unit.sv */
`timescale 1ns / 1ps

// Login-failure rate limiter over a linear-probed hash table of 1024 buckets
// in each of two banks, held in one single-port-read slot memory. One word is
// taken at a time; a word that is waiting on m_ready holds off the next one.
// Every probed slot of a lookup goes through the memory's registered read; the
// lockout, window and failure updates that follow share one time compare and
// add unit. A word with no source answers in the cycle after it is taken. When
// the occupied count reaches the compaction threshold, the next lookup first
// rebuilds the table into the other bank: it clears that bank, then reads each
// source slot and reinserts each live entry by probing. After reset the block
// clears the whole slot memory and takes no word meanwhile; configuration
// writes are taken at any time.
module failure_rate_limit_hash_table_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  frl_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output frl_pkg::rsp_t m_data,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_wdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_CCLR  = 4'd2;
    localparam logic [3:0] S_CRD   = 4'd3;
    localparam logic [3:0] S_CCHK  = 4'd4;
    localparam logic [3:0] S_CPRD  = 4'd5;
    localparam logic [3:0] S_CPCHK = 4'd6;
    localparam logic [3:0] S_PRD   = 4'd7;
    localparam logic [3:0] S_PCHK  = 4'd8;
    localparam logic [3:0] S_RES   = 4'd9;
    localparam logic [3:0] S_HLK   = 4'd10;
    localparam logic [3:0] S_HWIN  = 4'd11;
    localparam logic [3:0] S_HFAIL = 4'd12;

    localparam int BB = frl_pkg::BKT_BITS;
    localparam int SB = frl_pkg::SLOT_BITS;

    logic [3:0]                   state_reg;
    logic [SB-1:0]                clr_reg;
    logic                         bank_reg;
    logic [BB:0]                  occ_reg;
    logic [31:0]                  full_reg;
    logic [7:0]                   max_fail_reg;
    logic [15:0]                  window_reg;
    logic [15:0]                  lockout_reg;
    logic [15:0]                  idle_reg;
    logic [10:0]                  thr_reg;
    logic [frl_pkg::KEY_BITS-1:0] key_reg;
    logic                         fail_reg;
    logic [30:0]                  now_reg;
    logic [BB-1:0]                pos_reg;
    logic [BB-1:0]                cnt_reg;
    logic [BB-1:0]                src_reg;
    logic [BB:0]                  live_reg;
    logic                         tomb_seen_reg;
    logic [BB-1:0]                tomb_reg;
    logic                         empty_seen_reg;
    logic [BB-1:0]                empty_reg;
    logic [BB-1:0]                hit_reg;
    frl_pkg::slot_t               ent_reg;
    frl_pkg::rsp_t                res_reg;
    logic                         m_valid_reg;

    logic                         ram_we;
    logic [SB-1:0]                ram_waddr;
    frl_pkg::slot_t               ram_wdata;
    logic [SB-1:0]                ram_raddr;
    frl_pkg::slot_t               rd;
    frl_pkg::tu_req_t             tu_req;
    frl_pkg::tu_rsp_t             tu_rsp;
    frl_pkg::slot_t               fin;
    logic                         lock_now;
    logic [31:0]                  full_inc;
    logic [31:0]                  now_ext;
    logic                         live_slot;
    logic                         take;

    frl_ram #(
        .WIDTH ($bits(frl_pkg::slot_t)),
        .DEPTH (frl_pkg::SLOTS)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd)
    );

    frl_time_unit u_time (
        .req (tu_req),
        .rsp (tu_rsp)
    );

    assign s_ready   = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = res_reg;
    assign take      = s_valid && s_ready;
    assign now_ext   = {1'b0, now_reg};
    assign full_inc  = (full_reg == 32'hFFFF_FFFF) ? full_reg : full_reg + 32'd1;
    assign live_slot = (rd.status == frl_pkg::ST_ACTIVE) && !tu_rsp.elapsed_gt;

    // time unit operand select
    always_comb begin
        tu_req.a   = now_ext;
        tu_req.b   = rd.touch_time;
        tu_req.lim = idle_reg;
        unique case (state_reg)
            S_HLK: begin
                tu_req.a = ent_reg.lock_end;
                tu_req.b = now_ext;
            end
            S_HWIN: begin
                tu_req.b   = ent_reg.first_time;
                tu_req.lim = window_reg;
            end
            S_HFAIL: begin
                tu_req.lim = lockout_reg;
            end
            default: begin
            end
        endcase
    end

    // failure update of the hit entry
    always_comb begin
        fin        = ent_reg;
        fin.status = frl_pkg::ST_ACTIVE;
        lock_now   = 1'b0;
        if (fail_reg) begin
            if (ent_reg.failures == 8'd0) begin
                fin.first_time = now_ext;
            end
            if (ent_reg.failures != 8'hFF) begin
                fin.failures = ent_reg.failures + 8'd1;
            end
            fin.touch_time = now_ext;
            if (fin.failures >= max_fail_reg) begin
                fin.lock_end = tu_rsp.sum;
                lock_now     = 1'b1;
            end
        end
    end

    // memory port control
    always_comb begin
        ram_raddr = {bank_reg, pos_reg};
        ram_we    = 1'b0;
        ram_waddr = {bank_reg, pos_reg};
        ram_wdata = rd;
        unique case (state_reg)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            S_CCLR: begin
                ram_we    = 1'b1;
                ram_waddr = {~bank_reg, src_reg};
                ram_wdata = '0;
            end
            S_CRD: begin
                ram_raddr = {bank_reg, src_reg};
            end
            S_CPRD: begin
                ram_raddr = {~bank_reg, pos_reg};
            end
            S_CPCHK: begin
                ram_waddr = {~bank_reg, pos_reg};
                ram_wdata = ent_reg;
                ram_we    = (rd.status == frl_pkg::ST_EMPTY);
            end
            S_PCHK: begin
                ram_wdata        = rd;
                ram_wdata.status = frl_pkg::ST_TOMB;
                ram_we           = (rd.status == frl_pkg::ST_ACTIVE) && tu_rsp.elapsed_gt;
            end
            S_HFAIL: begin
                ram_we    = 1'b1;
                ram_waddr = {bank_reg, hit_reg};
                ram_wdata = fin;
            end
            default: begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_fail_reg <= frl_pkg::RST_MAX_FAILURES;
            window_reg   <= frl_pkg::RST_WINDOW;
            lockout_reg  <= frl_pkg::RST_LOCKOUT;
            idle_reg     <= frl_pkg::RST_IDLE_EXPIRY;
            thr_reg      <= frl_pkg::RST_COMPACT_THR;
        end else if (cfg_we) begin
            unique case (cfg_index)
                frl_pkg::CFG_MAX_FAILURES: max_fail_reg <= cfg_wdata[7:0];
                frl_pkg::CFG_WINDOW:       window_reg   <= cfg_wdata;
                frl_pkg::CFG_LOCKOUT:      lockout_reg  <= cfg_wdata;
                frl_pkg::CFG_IDLE_EXPIRY:  idle_reg     <= cfg_wdata;
                frl_pkg::CFG_COMPACT_THR:  thr_reg      <= cfg_wdata[10:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            bank_reg    <= 1'b0;
            occ_reg     <= '0;
            full_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        key_reg        <= s_data.key_digest;
                        fail_reg       <= s_data.fail_mark;
                        now_reg        <= s_data.now_seconds;
                        pos_reg        <= frl_pkg::home_of(s_data.key_digest);
                        cnt_reg        <= '0;
                        src_reg        <= '0;
                        tomb_seen_reg  <= 1'b0;
                        empty_seen_reg <= 1'b0;
                        if (!s_data.source_known) begin
                            res_reg     <= '{1'b0, frl_pkg::VERDICT_NOSRC, 1'b0, full_reg};
                            m_valid_reg <= 1'b1;
                        end else if (occ_reg >= thr_reg) begin
                            state_reg <= S_CCLR;
                        end else begin
                            state_reg <= S_PRD;
                        end
                    end
                end
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == {SB{1'b1}}) begin
                        state_reg <= S_IDLE;
                    end
                end
                // clear the destination bank
                S_CCLR: begin
                    src_reg <= src_reg + 1'b1;
                    if (src_reg == {BB{1'b1}}) begin
                        live_reg  <= '0;
                        state_reg <= S_CRD;
                    end
                end
                S_CRD: begin
                    state_reg <= S_CCHK;
                end
                S_CCHK: begin
                    if (live_slot) begin
                        ent_reg   <= rd;
                        pos_reg   <= frl_pkg::home_of(rd.key);
                        state_reg <= S_CPRD;
                    end else if (src_reg == {BB{1'b1}}) begin
                        bank_reg  <= ~bank_reg;
                        occ_reg   <= live_reg;
                        pos_reg   <= frl_pkg::home_of(key_reg);
                        state_reg <= S_PRD;
                    end else begin
                        src_reg   <= src_reg + 1'b1;
                        state_reg <= S_CRD;
                    end
                end
                S_CPRD: begin
                    state_reg <= S_CPCHK;
                end
                S_CPCHK: begin
                    if (rd.status != frl_pkg::ST_EMPTY) begin
                        pos_reg   <= pos_reg + 1'b1;
                        state_reg <= S_CPRD;
                    end else if (src_reg == {BB{1'b1}}) begin
                        bank_reg  <= ~bank_reg;
                        occ_reg   <= live_reg + 1'b1;
                        pos_reg   <= frl_pkg::home_of(key_reg);
                        state_reg <= S_PRD;
                    end else begin
                        live_reg  <= live_reg + 1'b1;
                        src_reg   <= src_reg + 1'b1;
                        state_reg <= S_CRD;
                    end
                end
                S_PRD: begin
                    state_reg <= S_PCHK;
                end
                // probe one slot
                S_PCHK: begin
                    if (rd.status == frl_pkg::ST_EMPTY) begin
                        empty_seen_reg <= 1'b1;
                        empty_reg      <= pos_reg;
                        state_reg      <= S_RES;
                    end else if (live_slot && rd.key == key_reg) begin
                        hit_reg   <= pos_reg;
                        ent_reg   <= rd;
                        state_reg <= S_HLK;
                    end else begin
                        if (!live_slot && !tomb_seen_reg) begin
                            tomb_seen_reg <= 1'b1;
                            tomb_reg      <= pos_reg;
                        end
                        if (cnt_reg == {BB{1'b1}}) begin
                            state_reg <= S_RES;
                        end else begin
                            cnt_reg   <= cnt_reg + 1'b1;
                            pos_reg   <= pos_reg + 1'b1;
                            state_reg <= S_PRD;
                        end
                    end
                end
                // key absent: insert, allow or report full
                S_RES: begin
                    if (empty_seen_reg || tomb_seen_reg) begin
                        if (!fail_reg) begin
                            res_reg     <= '{1'b1, frl_pkg::VERDICT_OK, 1'b0, full_reg};
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_IDLE;
                        end else begin
                            hit_reg <= tomb_seen_reg ? tomb_reg : empty_reg;
                            if (!tomb_seen_reg) begin
                                occ_reg <= occ_reg + 1'b1;
                            end
                            ent_reg   <= '{frl_pkg::ST_ACTIVE, key_reg, 8'd0, 32'd0, 32'd0,
                                           now_ext};
                            state_reg <= S_HLK;
                        end
                    end else begin
                        full_reg    <= full_inc;
                        res_reg     <= '{1'b0, frl_pkg::VERDICT_FULL, 1'b0, full_inc};
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_HLK: begin
                    if (tu_rsp.a_gt_b) begin
                        res_reg     <= '{1'b0, frl_pkg::VERDICT_LOCKED, 1'b0, full_reg};
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end else begin
                        state_reg <= S_HWIN;
                    end
                end
                // window expiry
                S_HWIN: begin
                    if (ent_reg.failures != 8'd0 && tu_rsp.elapsed_gt) begin
                        ent_reg.failures   <= 8'd0;
                        ent_reg.first_time <= 32'd0;
                        ent_reg.lock_end   <= 32'd0;
                    end
                    state_reg <= S_HFAIL;
                end
                S_HFAIL: begin
                    res_reg     <= '{1'b1, frl_pkg::VERDICT_OK, lock_now, full_reg};
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // occupancy never exceeds one bank
    assert property (@(posedge aclk) disable iff (!aresetn)
        {{(31-BB){1'b0}}, occ_reg} <= frl_pkg::BUCKETS)
        else $error("occupied count beyond bank size");

    // full-rejection count never goes down
    assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg >= $past(full_reg))
        else $error("full count decreased");

    // no word taken while a bank is cleared or a source slot is checked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLR || state_reg == S_CCLR || state_reg == S_CCHK) |-> !s_ready)
        else $error("word taken during table sweep");

    // a result appears only after a lookup step or a taken word
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(take) || $past(state_reg) == S_RES
            || $past(state_reg) == S_HLK || $past(state_reg) == S_HFAIL))
        else $error("result without a word");

endmodule
